// ----- hw/rtl/cmm_pkg.sv -----
package cmm_pkg;

   localparam int LANES             = 8;
   localparam int VALUE_WIDTH       = 64;
   localparam int LANE_COUNT_WIDTH  = 4;
   localparam int COUNT_WIDTH       = 32;
   localparam int RUN_OUT_WIDTH     = 32;
   localparam int RUN_WIDTH         = (COUNT_WIDTH < RUN_OUT_WIDTH) ? COUNT_WIDTH : RUN_OUT_WIDTH;
   localparam int LANE_NUM_WIDTH    = $clog2(LANES + 1);
   localparam int INC_WIDTH         = $clog2(LANES + 1);
   localparam int LEVELS            = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int TREE_SIZE         = 1 << LEVELS;
   localparam int IN_DATA_WIDTH     = ((LANES * VALUE_WIDTH + LANE_COUNT_WIDTH + 7) / 8) * 8;
   localparam int OUT_DATA_WIDTH    = ((3 * VALUE_WIDTH + RUN_OUT_WIDTH + 7) / 8) * 8;

   typedef logic [VALUE_WIDTH-1:0] value_type;

   typedef struct packed {
      value_type value;
      logic      valid;
      logic      step;
      logic      neq;
      logic      delta_bad;
   } lane_result_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic first_run;
   } item_info_type;

   typedef struct packed {
      value_type min_value;
      value_type max_value;
      logic      valid;
   } node_type;

   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic [INC_WIDTH-1:0] runs_inc;
      logic                 any_step;
      logic                 delta_bad;
   } summary_type;

   function automatic node_type merge_nodes(node_type a, node_type b);
      node_type r;
      if (!a.valid) begin
         r = b;
      end else if (!b.valid) begin
         r = a;
      end else begin
         r.valid     = 1'b1;
         r.min_value = ($signed(b.min_value) < $signed(a.min_value)) ? b.min_value : a.min_value;
         r.max_value = ($signed(a.max_value) < $signed(b.max_value)) ? b.max_value : a.max_value;
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/column_min_max_run_delta_stats_top.sv -----
// Column statistics over signed 64-bit values, up to eight per input word. A new word is
// taken every cycle whenever the output register is free or being emptied. Each lane checks
// its step against the previous value (the last value of the preceding word for lane 0),
// then a registered min/max tree of three levels reduces the lanes and an accumulator folds
// the word into the column totals; at a column's end the result goes to an output register.
// It gives min, max, a saturating run count and the configured delta when every neighbour
// step matched it, otherwise 0; an empty column gives all zeros. The user must write
// expected_delta via csr_write_enable / csr_write_data while the block is idle (not enforced).
module column_min_max_run_delta_stats_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [cmm_pkg::VALUE_WIDTH-1:0]     csr_write_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // value_lane0 .. value_lane7, lane_count, zero padding
   input  logic [cmm_pkg::IN_DATA_WIDTH-1:0]   req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // min_value, max_value, run_count, delta_result
   output logic [cmm_pkg::OUT_DATA_WIDTH-1:0]  rsp_tdata
);

   cmm_pkg::value_type             delta_ff;
   cmm_pkg::value_type             prev_value_ff, prev_value_in;
   logic                           prev_valid_ff, prev_valid_in;
   cmm_pkg::item_info_type         info_ff, info_in;
   cmm_pkg::value_type             lane_value [cmm_pkg::LANES];
   cmm_pkg::value_type             lane_pred  [cmm_pkg::LANES];
   logic [cmm_pkg::LANES-1:0]      lane_valid;
   logic [cmm_pkg::LANES-1:0]      lane_step;
   cmm_pkg::lane_result_type       lane_result [cmm_pkg::LANES];
   logic [cmm_pkg::LANE_COUNT_WIDTH-1:0] lane_count;
   logic [cmm_pkg::LANE_NUM_WIDTH-1:0]   lane_num;
   cmm_pkg::node_type              root;
   cmm_pkg::summary_type           summary;
   logic                           enable;
   logic                           accept;

   assign req_tready = enable;
   assign accept     = req_tvalid && enable;
   assign lane_count = req_tdata[cmm_pkg::LANES*cmm_pkg::VALUE_WIDTH +: cmm_pkg::LANE_COUNT_WIDTH];

   always_comb begin
      if (int'(lane_count) > cmm_pkg::LANES) begin
         lane_num = cmm_pkg::LANE_NUM_WIDTH'(cmm_pkg::LANES);
      end else begin
         lane_num = cmm_pkg::LANE_NUM_WIDTH'(lane_count);
      end
      prev_value_in = prev_value_ff;
      for (int i = 0; i < cmm_pkg::LANES; i++) begin
         lane_value[i] = req_tdata[i*cmm_pkg::VALUE_WIDTH +: cmm_pkg::VALUE_WIDTH];
         lane_valid[i] = int'(lane_num) > i;
         if (i == 0) begin
            lane_pred[i] = prev_value_ff;
            lane_step[i] = lane_valid[i] & prev_valid_ff;
         end else begin
            lane_pred[i] = lane_value[i-1];
            lane_step[i] = lane_valid[i];
         end
         if (lane_valid[i]) begin
            prev_value_in = lane_value[i];
         end
      end
      prev_valid_in     = !req_tlast && (prev_valid_ff || (lane_num != '0));
      info_in.valid     = req_tvalid;
      info_in.last      = req_tlast;
      info_in.first_run = !prev_valid_ff && (lane_num != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff      <= '0;
         prev_valid_ff <= 1'b0;
         info_ff       <= '0;
      end else begin
         if (csr_write_enable) begin
            delta_ff <= csr_write_data;
         end
         if (accept) begin
            prev_valid_ff <= prev_valid_in;
         end
         if (enable) begin
            info_ff <= info_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prev_value_ff <= prev_value_in;
      end
   end

   for (genvar g = 0; g < cmm_pkg::LANES; g++) begin : g_lane
      cmm_lane u_lane (
         .clock      (clock),
         .enable     (enable),
         .value      (lane_value[g]),
         .pred       (lane_pred[g]),
         .lane_valid (lane_valid[g]),
         .has_step   (lane_step[g]),
         .delta      (delta_ff),
         .result     (lane_result[g])
      );
   end

   cmm_merge u_merge (
      .clock   (clock),
      .reset   (reset),
      .enable  (enable),
      .info    (info_ff),
      .lanes   (lane_result),
      .root    (root),
      .summary (summary)
   );

   cmm_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .delta      (delta_ff),
      .root       (root),
      .summary    (summary),
      .rsp_tready (rsp_tready),
      .enable     (enable),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- hw/rtl/cmm_lane.sv -----
module cmm_lane (
   input  logic                     clock,
   input  logic                     enable,
   input  cmm_pkg::value_type       value,
   input  cmm_pkg::value_type       pred,
   input  logic                     lane_valid,
   input  logic                     has_step,
   input  cmm_pkg::value_type       delta,
   output cmm_pkg::lane_result_type result
);

   cmm_pkg::lane_result_type result_ff;
   cmm_pkg::lane_result_type result_in;
   cmm_pkg::value_type       step_value;

   always_comb begin
      step_value          = value - pred;
      result_in.value     = value;
      result_in.valid     = lane_valid;
      result_in.step      = has_step;
      result_in.neq       = has_step & (value != pred);
      result_in.delta_bad = has_step & (step_value != delta);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ----- hw/rtl/cmm_merge.sv -----
module cmm_merge (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  cmm_pkg::item_info_type   info,
   input  cmm_pkg::lane_result_type lanes [cmm_pkg::LANES],
   output cmm_pkg::node_type        root,
   output cmm_pkg::summary_type     summary
);

   cmm_pkg::node_type    all_nodes [1:2*cmm_pkg::TREE_SIZE-1];
   cmm_pkg::node_type    heap_ff   [1:cmm_pkg::TREE_SIZE-1];
   cmm_pkg::node_type    heap_in   [1:cmm_pkg::TREE_SIZE-1];
   cmm_pkg::summary_type summary_ff [1:cmm_pkg::LEVELS];
   cmm_pkg::summary_type summary_in;
   logic [cmm_pkg::INC_WIDTH-1:0] inc_sum;

   // leaves come straight from the lane registers, spare leaves stay empty
   always_comb begin
      for (int k = 1; k < cmm_pkg::TREE_SIZE; k++) begin
         all_nodes[k] = heap_ff[k];
      end
      for (int i = 0; i < cmm_pkg::TREE_SIZE; i++) begin
         if (i < cmm_pkg::LANES) begin
            all_nodes[cmm_pkg::TREE_SIZE + i].min_value = lanes[i].value;
            all_nodes[cmm_pkg::TREE_SIZE + i].max_value = lanes[i].value;
            all_nodes[cmm_pkg::TREE_SIZE + i].valid     = lanes[i].valid;
         end else begin
            all_nodes[cmm_pkg::TREE_SIZE + i] = '0;
         end
      end
      for (int k = 1; k < cmm_pkg::TREE_SIZE; k++) begin
         heap_in[k] = cmm_pkg::merge_nodes(all_nodes[2*k], all_nodes[2*k+1]);
      end
   end

   always_comb begin
      inc_sum = cmm_pkg::INC_WIDTH'(info.first_run);
      summary_in.any_step  = 1'b0;
      summary_in.delta_bad = 1'b0;
      for (int i = 0; i < cmm_pkg::LANES; i++) begin
         inc_sum = inc_sum + cmm_pkg::INC_WIDTH'(lanes[i].neq);
         summary_in.any_step  = summary_in.any_step | lanes[i].step;
         summary_in.delta_bad = summary_in.delta_bad | lanes[i].delta_bad;
      end
      summary_in.valid    = info.valid;
      summary_in.last     = info.last;
      summary_in.runs_inc = inc_sum;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 1; k < cmm_pkg::TREE_SIZE; k++) begin
            heap_ff[k] <= heap_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= cmm_pkg::LEVELS; s++) begin
            summary_ff[s] <= '0;
         end
      end else if (enable) begin
         summary_ff[1] <= summary_in;
         for (int s = 2; s <= cmm_pkg::LEVELS; s++) begin
            summary_ff[s] <= summary_ff[s-1];
         end
      end
   end

   assign root    = heap_ff[1];
   assign summary = summary_ff[cmm_pkg::LEVELS];

endmodule

// ----- hw/rtl/cmm_accum.sv -----
module cmm_accum (
   input  logic                                clock,
   input  logic                                reset,
   input  cmm_pkg::value_type                  delta,
   input  cmm_pkg::node_type                   root,
   input  cmm_pkg::summary_type                summary,
   input  logic                                rsp_tready,
   output logic                                enable,
   output logic                                rsp_tvalid,
   output logic [cmm_pkg::OUT_DATA_WIDTH-1:0]  rsp_tdata
);

   cmm_pkg::value_type             acc_min_ff, acc_max_ff;
   logic                           acc_valid_ff, acc_valid_in;
   logic [cmm_pkg::RUN_WIDTH-1:0]  acc_runs_ff, acc_runs_in;
   logic                           acc_step_ff, acc_step_in;
   logic                           acc_bad_ff, acc_bad_in;
   logic                           rsp_tvalid_ff, rsp_tvalid_in;
   logic [cmm_pkg::OUT_DATA_WIDTH-1:0] rsp_tdata_ff, rsp_tdata_in;

   cmm_pkg::node_type              acc_node, merged;
   logic [cmm_pkg::RUN_WIDTH:0]    runs_sum;
   logic [cmm_pkg::RUN_WIDTH-1:0]  runs_sat;
   cmm_pkg::value_type             out_min, out_max, out_delta;
   logic                           take;

   assign enable = !rsp_tvalid_ff || rsp_tready;
   assign take   = enable && summary.valid;

   always_comb begin
      acc_node.min_value = acc_min_ff;
      acc_node.max_value = acc_max_ff;
      acc_node.valid     = acc_valid_ff;
      merged   = cmm_pkg::merge_nodes(acc_node, root);
      runs_sum = {1'b0, acc_runs_ff} + (cmm_pkg::RUN_WIDTH + 1)'(summary.runs_inc);
      runs_sat = runs_sum[cmm_pkg::RUN_WIDTH] ? '1 : runs_sum[cmm_pkg::RUN_WIDTH-1:0];
      acc_step_in = acc_step_ff | summary.any_step;
      acc_bad_in  = acc_bad_ff | summary.delta_bad;
      acc_valid_in = merged.valid;
      acc_runs_in  = runs_sat;
      out_min   = merged.valid ? merged.min_value : '0;
      out_max   = merged.valid ? merged.max_value : '0;
      out_delta = (acc_step_in && !acc_bad_in && (delta != '0)) ? delta : '0;
      rsp_tdata_in = cmm_pkg::OUT_DATA_WIDTH'({out_delta,
                                               cmm_pkg::RUN_OUT_WIDTH'(runs_sat),
                                               out_max, out_min});
      rsp_tvalid_in = enable ? (summary.valid && summary.last) : rsp_tvalid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff  <= 1'b0;
         acc_runs_ff   <= '0;
         acc_step_ff   <= 1'b0;
         acc_bad_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (take) begin
            if (summary.last) begin
               acc_valid_ff <= 1'b0;
               acc_runs_ff  <= '0;
               acc_step_ff  <= 1'b0;
               acc_bad_ff   <= 1'b0;
            end else begin
               acc_valid_ff <= acc_valid_in;
               acc_runs_ff  <= acc_runs_in;
               acc_step_ff  <= acc_step_in;
               acc_bad_ff   <= acc_bad_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         acc_min_ff <= merged.min_value;
         acc_max_ff <= merged.max_value;
         if (summary.last) begin
            rsp_tdata_ff <= rsp_tdata_in;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import cmm_pkg::*;

   localparam int PAD_WIDTH = IN_DATA_WIDTH - LANES * VALUE_WIDTH - LANE_COUNT_WIDTH;
   localparam int DRAIN_CYCLES = 10;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_WORDS = 800;
   localparam int PHASE_WORDS = 100;
   localparam logic [VALUE_WIDTH-1:0] VALUE_MIN = 64'h8000_0000_0000_0000;
   localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = 64'h7fff_ffff_ffff_ffff;
   localparam logic [VALUE_WIDTH-1:0] VALUE_ONES = 64'hffff_ffff_ffff_ffff;

   typedef logic [LANES-1:0][VALUE_WIDTH-1:0] lane_vec_t;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0]   delta_result;
      logic [RUN_OUT_WIDTH-1:0] run_count;
      logic [VALUE_WIDTH-1:0]   max_value;
      logic [VALUE_WIDTH-1:0]   min_value;
   } column_stats_t;

   typedef enum int {
      COL_RANDOM,
      COL_PROGRESSION,
      COL_RUNS,
      COL_BROKEN,
      COL_EXTREMES
   } column_kind_t;

   class column_scoreboard;
      logic [VALUE_WIDTH-1:0] delta_reg;
      logic [VALUE_WIDTH-1:0] col_min;
      logic [VALUE_WIDTH-1:0] col_max;
      logic [VALUE_WIDTH-1:0] prev_value;
      logic [RUN_WIDTH-1:0]   runs;
      int unsigned            seen;
      bit                     steps_match;
      column_stats_t          expected_stats[$];
      int                     error_count;

      function new();
         delta_reg = '0;
         error_count = 0;
         clear_column();
      endfunction

      function void clear_column();
         col_min = '0;
         col_max = '0;
         prev_value = '0;
         runs = '0;
         seen = 0;
         steps_match = 1'b1;
      endfunction

      function void note_word(lane_vec_t lanes, logic [LANE_COUNT_WIDTH-1:0] count,
                              logic last);
         int n;
         logic [VALUE_WIDTH-1:0] v;
         column_stats_t r;
         n = (count > LANES) ? LANES : int'(count);
         for (int i = 0; i < n; i++) begin
            v = lanes[i];
            if (seen == 0) begin
               col_min = v;
               col_max = v;
               runs = RUN_WIDTH'(1);
               seen = 1;
            end else begin
               if ($signed(v) < $signed(col_min)) col_min = v;
               if ($signed(col_max) < $signed(v)) col_max = v;
               if (v != prev_value && runs != {RUN_WIDTH{1'b1}}) runs = runs + 1'b1;
               if (v - prev_value != delta_reg) steps_match = 1'b0;
               seen = 2;
            end
            prev_value = v;
         end
         if (last) begin
            r.min_value = col_min;
            r.max_value = col_max;
            r.run_count = RUN_OUT_WIDTH'(runs);
            r.delta_result = (steps_match && delta_reg != '0 && seen >= 2) ? delta_reg : '0;
            expected_stats.push_back(r);
            clear_column();
         end
      endfunction

      function void check_result(logic [OUT_DATA_WIDTH-1:0] data);
         column_stats_t got;
         column_stats_t want;
         got = data;
         if (expected_stats.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("unexpected result word %h", data);
            return;
         end
         want = expected_stats.pop_front();
         if (got.min_value !== want.min_value || got.max_value !== want.max_value ||
             got.run_count !== want.run_count || got.delta_result !== want.delta_result) begin
            error_count++;
            if (error_count <= 10) begin
               $display("mismatch: min exp %0d got %0d, max exp %0d got %0d",
                        $signed(want.min_value), $signed(got.min_value),
                        $signed(want.max_value), $signed(got.max_value));
               $display("          runs exp %0d got %0d, delta exp %0d got %0d",
                        want.run_count, got.run_count,
                        $signed(want.delta_result), $signed(got.delta_result));
            end
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_write_enable = 1'b0;
   logic [VALUE_WIDTH-1:0]       csr_write_data = '0;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [IN_DATA_WIDTH-1:0]     req_tdata = '0;
   logic                         req_tlast = 1'b0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [OUT_DATA_WIDTH-1:0]    rsp_tdata;

   column_scoreboard stats;
   bit gaps_on = 1'b1;
   bit stalls_on = 1'b1;
   int long_holds_asked = 0;
   int long_holds_done = 0;
   int hold_left = 0;
   int words_sent = 0;

   column_min_max_run_delta_stats_top uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] pick_extreme();
      case ($urandom_range(0, 7))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2: return '0;
         3: return '1;
         4: return 64'd1;
         5: return VALUE_MIN + 1;
         6: return VALUE_MAX - 1;
         default: return rand64();
      endcase
   endfunction

   // receiver: random stalls plus the occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (long_holds_done != long_holds_asked) begin
         long_holds_done++;
         hold_left = LONG_HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
         hold_left = pick_gap() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) stats.delta_reg = csr_write_data;
         if (req_tvalid && req_tready)
            stats.note_word(req_tdata[LANES*VALUE_WIDTH-1:0],
                            req_tdata[LANES*VALUE_WIDTH +: LANE_COUNT_WIDTH], req_tlast);
         if (rsp_tvalid && rsp_tready) stats.check_result(rsp_tdata);
      end
   end

   task automatic send_word(input lane_vec_t lanes, input logic [LANE_COUNT_WIDTH-1:0] count,
                            input logic last);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
      req_tdata <= {{PAD_WIDTH{1'b0}}, count, lanes};
      req_tlast <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (stats.expected_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_delta(input logic [VALUE_WIDTH-1:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_column(input column_kind_t kind, input int words);
      lane_vec_t lanes;
      logic [LANE_COUNT_WIDTH-1:0] count;
      logic [VALUE_WIDTH-1:0] v;
      int n;
      v = (kind == COL_RUNS) ? pick_extreme() : rand64();
      for (int w = 0; w < words; w++) begin
         if ($urandom_range(0, 3) == 0) count = LANE_COUNT_WIDTH'($urandom_range(0, 15));
         else count = LANE_COUNT_WIDTH'(LANES);
         n = (count > LANES) ? LANES : int'(count);
         for (int i = 0; i < LANES; i++) begin
            if (i >= n) begin
               lanes[i] = rand64();
            end else begin
               case (kind)
                  COL_PROGRESSION, COL_BROKEN: begin
                     lanes[i] = v;
                     v = v + stats.delta_reg;
                     if (kind == COL_BROKEN && $urandom_range(0, 15) == 0) v = v + 1;
                  end
                  COL_RUNS: begin
                     if ($urandom_range(0, 3) == 0) v = pick_extreme();
                     lanes[i] = v;
                  end
                  COL_EXTREMES: lanes[i] = pick_extreme();
                  default: lanes[i] = rand64();
               endcase
            end
         end
         send_word(lanes, count, w == words - 1);
      end
   endtask

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      lane_vec_t lanes;
      logic [VALUE_WIDTH-1:0] delta;
      column_kind_t kind;
      int phase;
      int phase_start;
      int pick;
      stats = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty column
      lanes = '0;
      send_word(lanes, LANE_COUNT_WIDTH'(0), 1'b1);

      // unit step over one full word
      write_delta(64'd1);
      for (int i = 0; i < LANES; i++) lanes[i] = VALUE_WIDTH'(i);
      send_word(lanes, LANE_COUNT_WIDTH'(LANES), 1'b1);

      // extremes, then an oversized lane count
      lanes = {VALUE_MIN, VALUE_MAX, VALUE_MAX, 64'd1, VALUE_ONES, 64'd0, VALUE_MAX, VALUE_MIN};
      send_word(lanes, LANE_COUNT_WIDTH'(LANES), 1'b0);
      for (int i = 0; i < LANES; i++) lanes[i] = VALUE_MIN;
      send_word(lanes, LANE_COUNT_WIDTH'(15), 1'b1);

      // step of -1 wrapping from min to max, split across words with an empty word
      write_delta('1);
      lanes = '0;
      lanes[0] = VALUE_MIN;
      lanes[1] = VALUE_MAX;
      send_word(lanes, LANE_COUNT_WIDTH'(2), 1'b0);
      send_word(lanes, LANE_COUNT_WIDTH'(0), 1'b0);
      lanes[0] = VALUE_MAX - 1;
      lanes[1] = VALUE_MAX - 2;
      send_word(lanes, LANE_COUNT_WIDTH'(2), 1'b1);

      // single value column
      lanes[0] = 64'd42;
      send_word(lanes, LANE_COUNT_WIDTH'(1), 1'b1);

      // delta changed part way through a column
      write_delta(64'd5);
      lanes = '0;
      lanes[0] = 64'd10;
      lanes[1] = 64'd15;
      lanes[2] = 64'd20;
      send_word(lanes, LANE_COUNT_WIDTH'(3), 1'b0);
      write_delta(64'd7);
      lanes[0] = 64'd27;
      lanes[1] = 64'd34;
      send_word(lanes, LANE_COUNT_WIDTH'(2), 1'b1);

      // largest and smallest deltas
      write_delta(VALUE_MAX);
      lanes = '0;
      lanes[1] = VALUE_MAX;
      send_word(lanes, LANE_COUNT_WIDTH'(2), 1'b1);
      write_delta(VALUE_MIN);
      lanes[1] = VALUE_MIN;
      send_word(lanes, LANE_COUNT_WIDTH'(2), 1'b1);

      // values then an empty closing word
      lanes[0] = 64'd3;
      lanes[1] = 64'd3;
      lanes[2] = 64'd9;
      send_word(lanes, LANE_COUNT_WIDTH'(3), 1'b0);
      send_word(lanes, LANE_COUNT_WIDTH'(0), 1'b1);

      phase = 0;
      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         case (phase % 6)
            0: delta = 64'd1;
            1: delta = '1;
            2: delta = VALUE_MAX;
            3: delta = VALUE_MIN;
            4: delta = '0;
            default: delta = ($urandom_range(0, 1) == 0) ? rand64() : 64'($urandom_range(2, 99));
         endcase
         write_delta(delta);
         gaps_on = (phase % 4 != 1);
         stalls_on = (phase % 4 != 1);
         if (phase == 2) begin
            gaps_on = 1'b0;
            long_holds_asked++;
         end
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS && words_sent < RANDOM_WORDS) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) kind = COL_PROGRESSION;
            else if (pick < 7) kind = COL_RUNS;
            else if (pick < 8) kind = COL_RANDOM;
            else if (pick < 9) kind = COL_BROKEN;
            else kind = COL_EXTREMES;
            run_column(kind, ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12)
                                                         : $urandom_range(1, 6));
         end
         phase++;
      end

      wait_idle();
      if (stats.error_count == 0 && stats.expected_stats.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
